// ----- src/srs_pkg.sv -----
// shared types and constants for the stepper ramp sequencer
// no dependencies; used by srs_front, srs_queue, srs_back and the top level
package srs_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned StepsW  = 32;
  localparam int unsigned RampW   = 11;
  localparam int unsigned PosW    = 32;
  localparam int unsigned CfgAddrW = 3;

  localparam logic [KindW-1:0] KIND_LOAD  = 3'd0;
  localparam logic [KindW-1:0] KIND_VEL   = 3'd1;
  localparam logic [KindW-1:0] KIND_POS   = 3'd2;
  localparam logic [KindW-1:0] KIND_BRAKE = 3'd3;
  localparam logic [KindW-1:0] KIND_EVENT = 3'd4;

  localparam logic [StepsW-1:0] CONST_ENDLESS = 32'hFFFF_FFFF;
  localparam logic [RampW-1:0]  RAMP_LENGTH_RST = 11'd300;

  // register index, taken from paddr[2]
  localparam logic REG_RAMP_LENGTH = 1'b0;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_BRAKE,
    OP_EVENT
  } op_e;

  typedef enum logic [1:0] {
    PH_ACCEL = 2'd0,
    PH_CONST = 2'd1,
    PH_DECEL = 2'd2,
    PH_STOP  = 2'd3
  } phase_e;

  typedef struct packed {
    op_e                op;
    logic [IdxW-1:0]    idx;
    logic [PeriodW-1:0] period;
    logic               dir;
    logic [RampW-1:0]   ramp;
    logic [StepsW-1:0]  const_steps;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- src/stepper_ramp_sequencer.sv -----
// stepper ramp sequencer top level: config port, front end, queue, back end
// a beat accepted into the queue is issued (period table read and beat
// registered), then committed to the output register; a result stall holds
// the commit, and no new beat is issued until the last one is committed
// reset: all control state and the ramp length register go to reset values;
// the period table is not cleared and holds unknown data until loaded
module stepper_ramp_sequencer #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [srs_pkg::CfgAddrW-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [srs_pkg::KindW-1:0]         kind_i,
  input  logic [srs_pkg::IdxW-1:0]          table_index_i,
  input  logic [srs_pkg::PeriodW-1:0]       table_period_i,
  input  logic                              velocity_direction_i,
  input  logic signed [srs_pkg::StepsW-1:0] move_steps_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [srs_pkg::PeriodW-1:0]       reload_value_o,
  output logic [srs_pkg::PeriodW-2:0]       compare_value_o,
  output logic                              reload_changed_o,
  output logic signed [srs_pkg::PosW-1:0]   position_o,
  output logic [1:0]                        phase_o,
  output logic                              direction_o,
  output logic                              running_o,
  output logic                              timer_stop_o
);

  logic [srs_pkg::RampW-1:0] ramp_length_q;
  logic                      cfg_wr;

  srs_pkg::q_stat_t q_stat;
  srs_pkg::item_t   push_item;
  srs_pkg::item_t   head_item;
  logic             push;
  logic             pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == srs_pkg::REG_RAMP_LENGTH) ? 32'(ramp_length_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_length_q <= srs_pkg::RAMP_LENGTH_RST;
    end else if (cfg_wr && paddr[2] == srs_pkg::REG_RAMP_LENGTH) begin
      ramp_length_q <= pwdata[srs_pkg::RampW-1:0];
    end
  end

  srs_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .kind_i              (kind_i),
    .table_index_i       (table_index_i),
    .table_period_i      (table_period_i),
    .velocity_direction_i(velocity_direction_i),
    .move_steps_i        (move_steps_i),
    .ramp_length_i       (ramp_length_q),
    .q_stat_i            (q_stat),
    .push_o              (push),
    .item_o              (push_item)
  );

  srs_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .item_i(push_item),
    .pop_i (pop),
    .item_o(head_item),
    .stat_o(q_stat)
  );

  srs_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_stat_i        (q_stat),
    .item_i          (head_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .reload_value_o  (reload_value_o),
    .compare_value_o (compare_value_o),
    .reload_changed_o(reload_changed_o),
    .position_o      (position_o),
    .phase_o         (phase_o),
    .direction_o     (direction_o),
    .running_o       (running_o),
    .timer_stop_o    (timer_stop_o)
  );

endmodule

// ----- src/srs_front.sv -----
// front end: accepts input beats, classifies them and works out move setup
// depends on srs_pkg; feeds srs_queue
module srs_front #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [srs_pkg::KindW-1:0]     kind_i,
  input  logic [srs_pkg::IdxW-1:0]      table_index_i,
  input  logic [srs_pkg::PeriodW-1:0]   table_period_i,
  input  logic                          velocity_direction_i,
  input  logic signed [srs_pkg::StepsW-1:0] move_steps_i,
  input  logic [srs_pkg::RampW-1:0]     ramp_length_i,
  input  srs_pkg::q_stat_t              q_stat_i,
  output logic                          push_o,
  output srs_pkg::item_t                item_o
);

  logic [srs_pkg::RampW-1:0]  ramp;
  logic [srs_pkg::RampW:0]    both;
  logic [srs_pkg::RampW:0]    both_m1;
  logic                       neg;
  logic [srs_pkg::StepsW-1:0] raw;
  logic [srs_pkg::StepsW:0]   diff;
  logic [srs_pkg::StepsW-1:0] const_steps;

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    if (ramp_length_i == '0) begin
      ramp = srs_pkg::RampW'(1);
    end else if (32'(ramp_length_i) > TABLE_DEPTH) begin
      ramp = srs_pkg::RampW'(TABLE_DEPTH);
    end else begin
      ramp = ramp_length_i;
    end
  end

  assign both    = {ramp, 1'b0};
  assign both_m1 = both - 1'b1;
  assign neg     = move_steps_i[srs_pkg::StepsW-1];
  assign raw     = $unsigned(move_steps_i);

  // |steps| - 2*ramp in one subtract: for negative steps -x - b == ~x - (b-1)
  assign diff = neg ? ({1'b0, ~raw} - 33'(both_m1)) : ({1'b0, raw} - 33'(both));
  assign const_steps = (!diff[srs_pkg::StepsW] && diff[srs_pkg::StepsW-1:0] != '0) ?
                       diff[srs_pkg::StepsW-1:0] : '0;

  always_comb begin
    item_o.idx         = table_index_i;
    item_o.period      = table_period_i;
    item_o.ramp        = ramp;
    item_o.dir         = 1'b0;
    item_o.const_steps = '0;
    unique case (kind_i)
      srs_pkg::KIND_LOAD: begin
        // entries beyond the table are dropped here
        item_o.op = (32'(table_index_i) < TABLE_DEPTH) ? srs_pkg::OP_LOAD : srs_pkg::OP_NONE;
      end
      srs_pkg::KIND_VEL: begin
        item_o.op          = srs_pkg::OP_START;
        item_o.dir         = velocity_direction_i;
        item_o.const_steps = srs_pkg::CONST_ENDLESS;
      end
      srs_pkg::KIND_POS: begin
        item_o.op          = srs_pkg::OP_START;
        item_o.dir         = neg;
        item_o.const_steps = const_steps;
      end
      srs_pkg::KIND_BRAKE: item_o.op = srs_pkg::OP_BRAKE;
      srs_pkg::KIND_EVENT: item_o.op = srs_pkg::OP_EVENT;
      default:             item_o.op = srs_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- src/srs_queue.sv -----
// two-entry queue of classified beats between front and back
// depends on srs_pkg
module srs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  srs_pkg::item_t   item_i,
  input  logic             pop_i,
  output srs_pkg::item_t   item_o,
  output srs_pkg::q_stat_t stat_o
);

  srs_pkg::item_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;

  assign item_o       = entry_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- src/srs_back.sv -----
// back end: period table, motion state, phase sequencing and output register
// depends on srs_pkg; pops beats from srs_queue
module srs_back #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  srs_pkg::q_stat_t                  q_stat_i,
  input  srs_pkg::item_t                    item_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [srs_pkg::PeriodW-1:0]       reload_value_o,
  output logic [srs_pkg::PeriodW-2:0]       compare_value_o,
  output logic                              reload_changed_o,
  output logic signed [srs_pkg::PosW-1:0]   position_o,
  output logic [1:0]                        phase_o,
  output logic                              direction_o,
  output logic                              running_o,
  output logic                              timer_stop_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam logic [31:0] DepthM1 = 32'(TABLE_DEPTH - 1);

  typedef enum logic {
    ST_ISSUE,
    ST_COMMIT
  } state_e;

  state_e st_q;

  logic [srs_pkg::PeriodW-1:0] mem [TABLE_DEPTH];
  logic [srs_pkg::PeriodW-1:0] rd_data_q;
  srs_pkg::item_t              cur_q;

  srs_pkg::phase_e             ph_q, ph_d;
  logic                        half_q, half_d;
  logic [31:0]                 step_q, step_d;
  logic [srs_pkg::StepsW-1:0]  cr_q, cr_d;
  logic [srs_pkg::RampW-1:0]   rr_q, rr_d;
  logic [srs_pkg::PosW-1:0]    pos_q, pos_d;
  logic                        dir_q, dir_d;
  logic                        run_q, run_d;
  logic [srs_pkg::PeriodW-1:0] reload_q, reload_d;
  logic                        changed_d, stop_d;

  logic                        out_valid_q;
  logic [srs_pkg::PeriodW-1:0] out_reload_q;
  logic                        out_changed_q;
  logic [srs_pkg::PosW-1:0]    out_pos_q;
  srs_pkg::phase_e             out_ph_q;
  logic                        out_dir_q;
  logic                        out_run_q;
  logic                        out_stop_q;

  logic                        issue;
  logic                        commit;
  logic [31:0]                 step_inc;
  logic [srs_pkg::RampW-1:0]   rr_dec;
  logic [srs_pkg::StepsW-1:0]  cr_dec;
  logic [31:0]                 rd_idx;
  logic [AddrW-1:0]            rd_addr;

  assign issue  = (st_q == ST_ISSUE) && !q_stat_i.empty;
  assign commit = (st_q == ST_COMMIT) && (!out_valid_q || !out_stall_i);
  assign pop_o  = issue;

  assign step_inc = step_q + 32'd1;
  assign rr_dec   = (rr_q != '0) ? rr_q - 1'b1 : rr_q;
  assign cr_dec   = (cr_q != '0) ? cr_q - 1'b1 : cr_q;

  // table index for the beat at the head: start reads entry zero, a counted
  // step reads the next ramp entry; past the end reads the last entry
  always_comb begin
    if (item_i.op == srs_pkg::OP_START) begin
      rd_idx = '0;
    end else if (ph_q == srs_pkg::PH_DECEL) begin
      rd_idx = 32'(rr_dec);
    end else begin
      rd_idx = step_inc;
    end
    rd_addr = (rd_idx > DepthM1) ? AddrW'(DepthM1) : AddrW'(rd_idx);
  end

  always_ff @(posedge clk_i) begin
    if (issue && item_i.op == srs_pkg::OP_LOAD) begin
      mem[AddrW'(item_i.idx)] <= item_i.period;
    end
    if (issue) begin
      rd_data_q <= mem[rd_addr];
      cur_q     <= item_i;
    end
  end

  always_comb begin
    ph_d      = ph_q;
    half_d    = half_q;
    step_d    = step_q;
    cr_d      = cr_q;
    rr_d      = rr_q;
    pos_d     = pos_q;
    dir_d     = dir_q;
    run_d     = run_q;
    reload_d  = reload_q;
    changed_d = 1'b0;
    stop_d    = 1'b0;
    unique case (cur_q.op)
      srs_pkg::OP_NONE, srs_pkg::OP_LOAD: begin
      end
      srs_pkg::OP_START: begin
        rr_d      = cur_q.ramp;
        cr_d      = cur_q.const_steps;
        half_d    = 1'b0;
        step_d    = '0;
        ph_d      = srs_pkg::PH_ACCEL;
        dir_d     = cur_q.dir;
        run_d     = 1'b1;
        reload_d  = rd_data_q;
        changed_d = 1'b1;
      end
      srs_pkg::OP_BRAKE: begin
        ph_d = srs_pkg::PH_STOP;
      end
      srs_pkg::OP_EVENT: begin
        if (run_q) begin
          half_d = ~half_q;
          // second compare event of a pair counts a step
          if (half_q) begin
            pos_d  = dir_q ? pos_q - 1'b1 : pos_q + 1'b1;
            step_d = step_inc;
            unique case (ph_q)
              srs_pkg::PH_ACCEL: begin
                reload_d  = rd_data_q;
                changed_d = 1'b1;
                if (rr_q == '0 || step_inc >= 32'(rr_q) - 32'd1) begin
                  ph_d = srs_pkg::PH_CONST;
                end
              end
              srs_pkg::PH_CONST: begin
                cr_d = cr_dec;
                if (cr_dec == '0) begin
                  ph_d = srs_pkg::PH_DECEL;
                end
              end
              srs_pkg::PH_DECEL: begin
                rr_d      = rr_dec;
                reload_d  = rd_data_q;
                changed_d = 1'b1;
                if (rr_dec == '0) begin
                  ph_d = srs_pkg::PH_STOP;
                end
              end
              srs_pkg::PH_STOP: begin
                step_d = '0;
                run_d  = 1'b0;
                stop_d = 1'b1;
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= ST_ISSUE;
      ph_q          <= srs_pkg::PH_STOP;
      half_q        <= 1'b0;
      step_q        <= '0;
      cr_q          <= '0;
      rr_q          <= '0;
      pos_q         <= '0;
      dir_q         <= 1'b0;
      run_q         <= 1'b0;
      reload_q      <= '0;
      out_valid_q   <= 1'b0;
      out_reload_q  <= '0;
      out_changed_q <= 1'b0;
      out_pos_q     <= '0;
      out_ph_q      <= srs_pkg::PH_STOP;
      out_dir_q     <= 1'b0;
      out_run_q     <= 1'b0;
      out_stop_q    <= 1'b0;
    end else begin
      unique case (st_q)
        ST_ISSUE: begin
          if (issue) begin
            st_q <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (commit) begin
            st_q <= ST_ISSUE;
          end
        end
      endcase
      if (commit) begin
        ph_q          <= ph_d;
        half_q        <= half_d;
        step_q        <= step_d;
        cr_q          <= cr_d;
        rr_q          <= rr_d;
        pos_q         <= pos_d;
        dir_q         <= dir_d;
        run_q         <= run_d;
        reload_q      <= reload_d;
        out_valid_q   <= 1'b1;
        out_reload_q  <= reload_d;
        out_changed_q <= changed_d;
        out_pos_q     <= pos_d;
        out_ph_q      <= ph_d;
        out_dir_q     <= dir_d;
        out_run_q     <= run_d;
        out_stop_q    <= stop_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign reload_value_o   = out_reload_q;
  assign compare_value_o  = out_reload_q[srs_pkg::PeriodW-1:1];
  assign reload_changed_o = out_changed_q;
  assign position_o       = $signed(out_pos_q);
  assign phase_o          = out_ph_q;
  assign direction_o      = out_dir_q;
  assign running_o        = out_run_q;
  assign timer_stop_o     = out_stop_q;

`ifndef SYNTH
  a_stop_no_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(reload_changed_o && timer_stop_o))
    else $error("stop beat also reports a reload change");

  a_stop_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && timer_stop_o) |-> (!running_o && phase_o == srs_pkg::PH_STOP))
    else $error("stop beat while still running");

  a_idle_half_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |-> !half_q)
    else $error("half step pending while not running");

  a_pop_then_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (st_q == ST_COMMIT))
    else $error("popped beat not carried to commit");
`endif

endmodule

// ----- test/srs_checker.sv -----
`timescale 1ns / 100ps
// scoreboard for the stepper ramp sequencer: follows the config port and both
// beat channels, predicts every result and compares it field by field
// depends on srs_pkg for field widths, kind codes and phase codes
module srs_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [srs_pkg::CfgAddrW-1:0]  paddr_i,
  input  logic [31:0]                   pwdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [srs_pkg::KindW-1:0]     kind_i,
  input  logic [srs_pkg::IdxW-1:0]      table_index_i,
  input  logic [srs_pkg::PeriodW-1:0]   table_period_i,
  input  logic                          velocity_direction_i,
  input  logic [srs_pkg::StepsW-1:0]    move_steps_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [srs_pkg::PeriodW-1:0]   reload_value_i,
  input  logic [srs_pkg::PeriodW-2:0]   compare_value_i,
  input  logic                          reload_changed_i,
  input  logic [srs_pkg::PosW-1:0]      position_i,
  input  logic [1:0]                    phase_i,
  input  logic                          direction_i,
  input  logic                          running_i,
  input  logic                          timer_stop_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);

  localparam int unsigned TableDepth = 1024;

  typedef struct packed {
    logic [srs_pkg::PeriodW-1:0] reload;
    logic [srs_pkg::PeriodW-2:0] compare;
    logic                        changed;
    logic [srs_pkg::PosW-1:0]    position;
    srs_pkg::phase_e             phase;
    logic                        direction;
    logic                        running;
    logic                        stopped;
  } motion_t;

  motion_t                     expected_motion[$];
  logic [srs_pkg::PeriodW-1:0] period_mem [TableDepth];
  logic [srs_pkg::RampW-1:0]   ramp_cfg;
  srs_pkg::phase_e             phase_q;
  logic                        half_q;
  logic                        dir_q;
  logic                        run_q;
  logic [31:0]                 count_q;
  logic [31:0]                 cruise_q;
  logic [31:0]                 ramp_left_q;
  logic [31:0]                 pos_q;
  logic [srs_pkg::PeriodW-1:0] reload_q;
  int unsigned                 fails = 0;

  function automatic logic [srs_pkg::PeriodW-1:0] period_at(input logic [31:0] idx);
    // ramp reads past the end stick at the last entry
    if (idx >= TableDepth) return period_mem[TableDepth-1];
    return period_mem[idx[srs_pkg::IdxW-1:0]];
  endfunction

  task automatic begin_move(input logic [31:0] ramp, input logic [31:0] cruise,
                            input logic dir);
    ramp_left_q = ramp;
    cruise_q    = cruise;
    half_q      = 1'b0;
    count_q     = '0;
    phase_q     = srs_pkg::PH_ACCEL;
    dir_q       = dir;
    run_q       = 1'b1;
    reload_q    = period_at(32'd0);
  endtask

  task automatic predict_motion(input logic [srs_pkg::KindW-1:0] kind,
                                input logic [srs_pkg::IdxW-1:0] idx,
                                input logic [srs_pkg::PeriodW-1:0] per,
                                input logic vdir,
                                input logic [srs_pkg::StepsW-1:0] steps,
                                output motion_t res);
    logic [31:0] ramp;
    logic [31:0] mag;
    logic [31:0] cruise;
    logic        changed;
    logic        stopped;
    changed = 1'b0;
    stopped = 1'b0;
    ramp = 32'(ramp_cfg);
    if (ramp < 32'd1) ramp = 32'd1;
    if (ramp > TableDepth) ramp = TableDepth;
    case (kind)
      srs_pkg::KIND_LOAD: begin
        if (idx < TableDepth) period_mem[idx] = per;
      end
      srs_pkg::KIND_VEL: begin
        begin_move(ramp, srs_pkg::CONST_ENDLESS, vdir);
        changed = 1'b1;
      end
      srs_pkg::KIND_POS: begin
        mag = steps[srs_pkg::StepsW-1] ? 32'd0 - steps : steps;
        // short moves get a zero constant count rather than a wrapped count
        cruise = (mag > 32'd2 * ramp) ? mag - 32'd2 * ramp : 32'd0;
        begin_move(ramp, cruise, steps[srs_pkg::StepsW-1]);
        changed = 1'b1;
      end
      srs_pkg::KIND_BRAKE: begin
        phase_q = srs_pkg::PH_STOP;
      end
      srs_pkg::KIND_EVENT: begin
        if (run_q) begin
          half_q = ~half_q;
          // a step is counted on every second compare event
          if (!half_q) begin
            pos_q   = dir_q ? pos_q - 32'd1 : pos_q + 32'd1;
            count_q = count_q + 32'd1;
            case (phase_q)
              srs_pkg::PH_ACCEL: begin
                reload_q = period_at(count_q);
                changed  = 1'b1;
                if (count_q >= ramp_left_q - 32'd1 || ramp_left_q == 32'd0)
                  phase_q = srs_pkg::PH_CONST;
              end
              srs_pkg::PH_CONST: begin
                if (cruise_q > 32'd0) cruise_q = cruise_q - 32'd1;
                if (cruise_q < 32'd1) phase_q = srs_pkg::PH_DECEL;
              end
              srs_pkg::PH_DECEL: begin
                if (ramp_left_q > 32'd0) ramp_left_q = ramp_left_q - 32'd1;
                reload_q = period_at(ramp_left_q);
                changed  = 1'b1;
                if (ramp_left_q < 32'd1) phase_q = srs_pkg::PH_STOP;
              end
              default: begin
                count_q = '0;
                run_q   = 1'b0;
                stopped = 1'b1;
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    res.reload    = reload_q;
    res.compare   = reload_q[srs_pkg::PeriodW-1:1];
    res.changed   = changed;
    res.position  = pos_q;
    res.phase     = phase_q;
    res.direction = dir_q;
    res.running   = run_q;
    res.stopped   = stopped;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    motion_t want;
    if (!rst_ni) begin
      ramp_cfg    = srs_pkg::RAMP_LENGTH_RST;
      phase_q     = srs_pkg::PH_STOP;
      half_q      = 1'b0;
      dir_q       = 1'b0;
      run_q       = 1'b0;
      count_q     = '0;
      cruise_q    = '0;
      ramp_left_q = '0;
      pos_q       = '0;
      reload_q    = '0;
      expected_motion.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[2] == srs_pkg::REG_RAMP_LENGTH)
        ramp_cfg = pwdata_i[srs_pkg::RampW-1:0];
      if (out_valid_i && !out_stall_i) begin
        if (expected_motion.size() == 0) begin
          $display("%0t unexpected result beat: expected none, actual reload %0h position %0h",
                   $time, reload_value_i, position_i);
          fails++;
        end else begin
          want = expected_motion.pop_front();
          check_field("reload_value", 32'(want.reload), 32'(reload_value_i));
          check_field("compare_value", 32'(want.compare), 32'(compare_value_i));
          check_field("reload_changed", 32'(want.changed), 32'(reload_changed_i));
          check_field("position", want.position, position_i);
          check_field("phase", 32'(want.phase), 32'(phase_i));
          check_field("direction", 32'(want.direction), 32'(direction_i));
          check_field("running", 32'(want.running), 32'(running_i));
          check_field("timer_stop", 32'(want.stopped), 32'(timer_stop_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_motion(kind_i, table_index_i, table_period_i, velocity_direction_i,
                       move_steps_i, want);
        expected_motion.push_back(want);
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_motion.size();
  end

endmodule

// ----- test/stepper_ramp_sequencer_tb.sv -----
`timescale 1ns / 100ps
// top of the stepper ramp sequencer testbench: clock, reset, ramp length
// writes and beat stimulus; srs_checker predicts and compares the results
// depends on srs_pkg, stepper_ramp_sequencer and srs_checker
module stepper_ramp_sequencer_tb;

  localparam int unsigned Segments     = 11;
  localparam int unsigned SegmentBeats = 100;
  localparam int unsigned DrainCycles  = 100000;
  localparam int unsigned TableSize    = 1024;
  // long ramps are only run partway, so only the low table entries get read
  localparam int unsigned FillCap      = 128;
  localparam int unsigned BurstCap     = 100;
  localparam logic [srs_pkg::KindW-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [srs_pkg::KindW-1:0] KIND_SPARE_HI = 3'd7;

  logic                         clk_i;
  logic                         rst_ni = 1'b0;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [srs_pkg::CfgAddrW-1:0] paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [srs_pkg::KindW-1:0]    kind = '0;
  logic [srs_pkg::IdxW-1:0]     table_index = '0;
  logic [srs_pkg::PeriodW-1:0]  table_period = '0;
  logic                         velocity_direction = 1'b0;
  logic [srs_pkg::StepsW-1:0]   move_steps = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [srs_pkg::PeriodW-1:0]  reload_value;
  logic [srs_pkg::PeriodW-2:0]  compare_value;
  logic                         reload_changed;
  logic [srs_pkg::PosW-1:0]     position;
  logic [1:0]                   phase;
  logic                         direction;
  logic                         running;
  logic                         timer_stop;

  int unsigned                  fail_count;
  int unsigned                  pending;
  bit                           loaded [TableSize];
  bit                           stuck = 1'b0;
  int unsigned                  gap_odds = 0;
  int unsigned                  stall_odds = 0;
  int unsigned                  stall_left = 0;
  int unsigned                  beats_sent = 0;
  logic [srs_pkg::RampW-1:0]    ramp_now = srs_pkg::RAMP_LENGTH_RST;
  int unsigned                  ramp_plan [Segments] = '{300, 2, 1, 0, 6, 2047, 12, 1024, 4,
                                                         25, 3};
  int unsigned                  odds_menu [4] = '{0, 3, 8, 20};

  stepper_ramp_sequencer DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .kind_i               (kind),
    .table_index_i        (table_index),
    .table_period_i       (table_period),
    .velocity_direction_i (velocity_direction),
    .move_steps_i         (move_steps),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .reload_value_o       (reload_value),
    .compare_value_o      (compare_value),
    .reload_changed_o     (reload_changed),
    .position_o           (position),
    .phase_o              (phase),
    .direction_o          (direction),
    .running_o            (running),
    .timer_stop_o         (timer_stop)
  );

  srs_checker motion_check (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel_i               (psel),
    .penable_i            (penable),
    .pwrite_i             (pwrite),
    .pready_i             (pready),
    .paddr_i              (paddr),
    .pwdata_i             (pwdata),
    .in_valid_i           (in_valid),
    .in_stall_i           (in_stall),
    .kind_i               (kind),
    .table_index_i        (table_index),
    .table_period_i       (table_period),
    .velocity_direction_i (velocity_direction),
    .move_steps_i         (move_steps),
    .out_valid_i          (out_valid),
    .out_stall_i          (out_stall),
    .reload_value_i       (reload_value),
    .compare_value_i      (compare_value),
    .reload_changed_i     (reload_changed),
    .position_i           (position),
    .phase_i              (phase),
    .direction_i          (direction),
    .running_i            (running),
    .timer_stop_i         (timer_stop),
    .fail_count_o         (fail_count),
    .pending_o            (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // result side back-pressure in random bursts
  always @(posedge clk_i) begin
    if (stall_left == 0 && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
      stall_left = $urandom_range(1, 19);
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int unsigned ramp_span();
    if (ramp_now == 0) return 1;
    if (ramp_now > TableSize) return TableSize;
    return ramp_now;
  endfunction

  function automatic logic [srs_pkg::PeriodW-1:0] pick_period();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return srs_pkg::PeriodW'($urandom);
    endcase
  endfunction

  task automatic send_beat(input logic [srs_pkg::KindW-1:0] k,
                           input logic [srs_pkg::IdxW-1:0] idx,
                           input logic [srs_pkg::PeriodW-1:0] per, input logic vdir,
                           input logic [srs_pkg::StepsW-1:0] steps);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid           <= 1'b1;
    kind               <= k;
    table_index        <= idx;
    table_period       <= per;
    velocity_direction <= vdir;
    move_steps         <= steps;
    if (k == srs_pkg::KIND_LOAD) loaded[idx] = 1'b1;
    beats_sent++;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic fire_events(input int unsigned n);
    repeat (n) send_beat(srs_pkg::KIND_EVENT, srs_pkg::IdxW'($urandom),
                         srs_pkg::PeriodW'($urandom), 1'($urandom), $urandom);
  endtask

  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending != 0 && waited < DrainCycles);
    if (pending != 0) stuck = 1'b1;
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    int unsigned     seg;
    int unsigned     r;
    int unsigned     sel;
    int unsigned     seg_base;
    int unsigned     fill;
    int unsigned     fill_top;
    logic [31:0]     steps_v;
    logic [31:0]     mag_v;
    logic [31:0]     cruise_v;
    longint unsigned full_steps;
    bit              velocity;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (seg = 0; seg < Segments; seg++) begin
      // the first segment runs on the reset ramp length
      if (seg != 0) begin
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {srs_pkg::REG_RAMP_LENGTH, 2'b00};
        pwdata  <= 32'(ramp_plan[seg]);
        @(posedge clk_i);
        penable <= 1'b1;
        do @(posedge clk_i); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ramp_now = srs_pkg::RampW'(ramp_plan[seg]);
      end
      gap_odds   = (seg == Segments - 1) ? 0 : odds_menu[$urandom_range(0, 3)];
      stall_odds = (seg == Segments - 1) ? 0 : odds_menu[$urandom_range(0, 3)];

      // every entry a move can read must hold a period first; long ramps never
      // get past the low entries within one segment
      r = ramp_span();
      fill_top = (r > FillCap) ? FillCap : ((r > 2) ? r : 2);
      for (fill = 0; fill < fill_top; fill++)
        if (!loaded[fill])
          send_beat(srs_pkg::KIND_LOAD, srs_pkg::IdxW'(fill), pick_period(), 1'($urandom),
                    $urandom);

      if (seg == 0) begin
        send_beat(srs_pkg::KIND_LOAD, '0, '1, 1'b0, '0);
        send_beat(srs_pkg::KIND_LOAD, '1, '0, 1'b1, '1);
        fire_events(1);
        send_beat(srs_pkg::KIND_BRAKE, '0, '0, 1'b0, '0);
        send_beat(KIND_SPARE_LO, '1, '1, 1'b1, '1);
        send_beat(KIND_SPARE_HI, '0, '0, 1'b0, '0);
        send_beat(srs_pkg::KIND_VEL, '0, '0, 1'b1, '0);
        fire_events(3);
        send_beat(srs_pkg::KIND_BRAKE, '1, '1, 1'b1, '1);
        fire_events(2);
        send_beat(srs_pkg::KIND_POS, '0, '0, 1'b0, 32'h8000_0000);
        fire_events(2);
        // restart while still moving keeps the position
        send_beat(srs_pkg::KIND_POS, '0, '0, 1'b1, 32'h7FFF_FFFF);
        fire_events(2);
        send_beat(srs_pkg::KIND_BRAKE, '0, '0, 1'b0, '0);
        fire_events(2);
        send_beat(srs_pkg::KIND_POS, '0, '0, 1'b0, 32'h0000_0000);
        fire_events(2);
      end

      seg_base = beats_sent;
      while (beats_sent - seg_base < SegmentBeats) begin
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
          send_beat(srs_pkg::KindW'($urandom), srs_pkg::IdxW'($urandom), pick_period(),
                    1'($urandom), $urandom);
        end else if (sel < 20) begin
          repeat ($urandom_range(1, 3))
            send_beat(srs_pkg::KIND_LOAD, srs_pkg::IdxW'($urandom), pick_period(),
                      1'($urandom), $urandom);
        end else begin
          velocity   = ($urandom_range(0, 2) == 0);
          full_steps = 0;
          if (velocity) begin
            send_beat(srs_pkg::KIND_VEL, srs_pkg::IdxW'($urandom),
                      srs_pkg::PeriodW'($urandom), 1'($urandom), $urandom);
          end else begin
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
              steps_v = $urandom;
            end else if (sel == 1) begin
              case ($urandom_range(0, 4))
                0:       steps_v = 32'h8000_0000;
                1:       steps_v = 32'h7FFF_FFFF;
                2:       steps_v = 32'h0000_0000;
                3:       steps_v = 32'h0000_0001;
                default: steps_v = 32'hFFFF_FFFF;
              endcase
            end else begin
              mag_v   = $urandom_range(0, 2 * r + 40);
              steps_v = $urandom_range(0, 1) ? 32'd0 - mag_v : mag_v;
            end
            mag_v    = steps_v[31] ? 32'd0 - steps_v : steps_v;
            cruise_v = (mag_v > 2 * r) ? mag_v - 2 * r : 32'd0;
            // steps from start to the stop strobe
            full_steps = 64'((r > 1) ? r - 1 : 1) + 64'((cruise_v > 0) ? cruise_v : 32'd1)
                         + 64'(r) + 64'd1;
            send_beat(srs_pkg::KIND_POS, srs_pkg::IdxW'($urandom),
                      srs_pkg::PeriodW'($urandom), 1'($urandom), steps_v);
          end
          if (!velocity && r <= FillCap && full_steps <= 300) begin
            fire_events(2 * int'(full_steps) + $urandom_range(0, 3));
          end else begin
            fire_events($urandom_range(1, (r > FillCap) ? BurstCap : 2 * r + 60));
            // otherwise the next start restarts the move
            if ($urandom_range(0, 9) < 7) begin
              send_beat(srs_pkg::KIND_BRAKE, srs_pkg::IdxW'($urandom),
                        srs_pkg::PeriodW'($urandom), 1'($urandom), $urandom);
              fire_events($urandom_range(1, 5));
            end
          end
        end
      end

      // brake and finish the pending step so no move runs on into the next segment
      send_beat(srs_pkg::KIND_BRAKE, '0, '0, 1'b0, '0);
      fire_events(2);
    end

    wait_drained();
    if (fail_count == 0 && !stuck) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- stepper_ramp_sequencer.f -----
src/srs_pkg.sv
src/srs_front.sv
src/srs_queue.sv
src/srs_back.sv
src/stepper_ramp_sequencer.sv
test/srs_checker.sv
test/stepper_ramp_sequencer_tb.sv
